// ===== sv/cndf_pkg.sv =====
package cndf_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int MIN_DIST_WIDTH = 8;
    localparam int THRESH_WIDTH = 2 * MIN_DIST_WIDTH;
    localparam int SQ_WIDTH = 16;
    localparam int SUM_WIDTH = SQ_WIDTH + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_WIDTH = $clog2(FIFO_DEPTH);
    localparam int CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

    localparam logic [MIN_DIST_WIDTH-1:0] MIN_DIST_RESET = MIN_DIST_WIDTH'(3);
    localparam logic [THRESH_WIDTH-1:0] THRESH_SQ_RESET = THRESH_WIDTH'(3 * 3);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        logic   has_point;
        logic   end_of_contour;
    } result_t;

    typedef struct packed {
        logic ge;
        logic gt;
    } dist_cmp_t;

    typedef struct packed {
        logic    push0_en;
        logic    push1_en;
        result_t push0_res;
        result_t push1_res;
    } push_t;

endpackage

// ===== sv/cndf_point_if.sv =====
interface cndf_point_if;
    import cndf_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

// ===== sv/cndf_result_if.sv =====
interface cndf_result_if;
    import cndf_pkg::*;

    logic   valid;
    logic   ready;
    coord_t out_x;
    coord_t out_y;
    logic   has_point;
    logic   end_of_contour;

    modport source (output valid, output out_x, output out_y, output has_point,
                    output end_of_contour, input ready);
    modport sink (input valid, input out_x, input out_y, input has_point,
                  input end_of_contour, output ready);
endinterface

// ===== sv/cndf_dist.sv =====
module cndf_dist (
    input  cndf_pkg::coord_t                          a_x,
    input  cndf_pkg::coord_t                          a_y,
    input  cndf_pkg::coord_t                          b_x,
    input  cndf_pkg::coord_t                          b_y,
    input  logic [cndf_pkg::THRESH_WIDTH-1:0]         thresh_sq,
    output cndf_pkg::dist_cmp_t                       cmp
);
    import cndf_pkg::*;

    logic signed [COORD_WIDTH:0] diff_x;
    logic signed [COORD_WIDTH:0] diff_y;
    logic [COORD_WIDTH:0]        neg_x;
    logic [COORD_WIDTH:0]        neg_y;
    logic [COORD_WIDTH-1:0]      mag_x;
    logic [COORD_WIDTH-1:0]      mag_y;
    logic                        big_x;
    logic                        big_y;
    logic [SQ_WIDTH-1:0]         sq_x;
    logic [SQ_WIDTH-1:0]         sq_y;
    logic [SUM_WIDTH-1:0]        sum;
    logic [SUM_WIDTH-1:0]        thresh_ext;
    logic                        far;

    assign diff_x = {a_x[COORD_WIDTH-1], a_x} - {b_x[COORD_WIDTH-1], b_x};
    assign diff_y = {a_y[COORD_WIDTH-1], a_y} - {b_y[COORD_WIDTH-1], b_y};
    assign neg_x  = -diff_x;
    assign neg_y  = -diff_y;
    assign mag_x  = diff_x[COORD_WIDTH] ? neg_x[COORD_WIDTH-1:0] : diff_x[COORD_WIDTH-1:0];
    assign mag_y  = diff_y[COORD_WIDTH] ? neg_y[COORD_WIDTH-1:0] : diff_y[COORD_WIDTH-1:0];

    // A difference of 256 or more is always beyond the largest threshold.
    if (COORD_WIDTH > 8) begin : g_wide
        assign big_x = |mag_x[COORD_WIDTH-1:8];
        assign big_y = |mag_y[COORD_WIDTH-1:8];
    end else begin : g_narrow
        assign big_x = 1'b0;
        assign big_y = 1'b0;
    end

    assign sq_x       = SQ_WIDTH'(mag_x[7:0]) * SQ_WIDTH'(mag_x[7:0]);
    assign sq_y       = SQ_WIDTH'(mag_y[7:0]) * SQ_WIDTH'(mag_y[7:0]);
    assign sum        = SUM_WIDTH'(sq_x) + SUM_WIDTH'(sq_y);
    assign thresh_ext = SUM_WIDTH'(thresh_sq);
    assign far        = big_x | big_y;

    assign cmp.ge = far | (sum >= thresh_ext);
    assign cmp.gt = far | (sum > thresh_ext);

endmodule

// ===== sv/cndf_core.sv =====
module cndf_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cndf_pkg::MIN_DIST_WIDTH-1:0] cfg_wr_data,
    cndf_point_if.sink                          point,
    input  logic [cndf_pkg::CNT_WIDTH-1:0]      fifo_free,
    output cndf_pkg::push_t                     push
);
    import cndf_pkg::*;

    logic                    in_valid_reg;
    coord_t                  px_reg;
    coord_t                  py_reg;
    logic                    last_reg;
    coord_t                  first_x_reg;
    coord_t                  first_y_reg;
    coord_t                  kept_x_reg;
    coord_t                  kept_y_reg;
    logic                    in_contour_reg;
    logic [THRESH_WIDTH-1:0] thresh_sq_reg;
    logic [THRESH_WIDTH-1:0] thresh_sq_next;

    dist_cmp_t               cmp_pk;
    dist_cmp_t               cmp_fk;
    dist_cmp_t               cmp_fp;
    logic                    emit_point;
    logic                    close_far;
    logic [CNT_WIDTH-1:0]    need;
    logic                    consume;
    logic                    take;
    result_t                 point_res;
    result_t                 end_res;

    cndf_dist u_dist_pk (
        .a_x       (px_reg),
        .a_y       (py_reg),
        .b_x       (kept_x_reg),
        .b_y       (kept_y_reg),
        .thresh_sq (thresh_sq_reg),
        .cmp       (cmp_pk)
    );

    cndf_dist u_dist_fk (
        .a_x       (first_x_reg),
        .a_y       (first_y_reg),
        .b_x       (kept_x_reg),
        .b_y       (kept_y_reg),
        .thresh_sq (thresh_sq_reg),
        .cmp       (cmp_fk)
    );

    cndf_dist u_dist_fp (
        .a_x       (first_x_reg),
        .a_y       (first_y_reg),
        .b_x       (px_reg),
        .b_y       (py_reg),
        .thresh_sq (thresh_sq_reg),
        .cmp       (cmp_fp)
    );

    assign thresh_sq_next = THRESH_WIDTH'(cfg_wr_data) * THRESH_WIDTH'(cfg_wr_data);

    // The closing test runs against the kept point as it stands after this point.
    assign emit_point = in_contour_reg & cmp_pk.ge;
    assign close_far  = in_contour_reg & (emit_point ? cmp_fp.gt : cmp_fk.gt);
    assign need       = CNT_WIDTH'(emit_point) + CNT_WIDTH'(last_reg);
    assign consume    = in_valid_reg & (need <= fifo_free);
    assign point.ready = ~in_valid_reg | consume;
    assign take       = point.valid & point.ready;

    always_comb
    begin
        point_res.out_x          = px_reg;
        point_res.out_y          = py_reg;
        point_res.has_point      = 1'b1;
        point_res.end_of_contour = 1'b0;
        end_res.out_x            = close_far ? first_x_reg : '0;
        end_res.out_y            = close_far ? first_y_reg : '0;
        end_res.has_point        = close_far;
        end_res.end_of_contour   = 1'b1;

        push.push0_en  = consume & (emit_point | last_reg);
        push.push1_en  = consume & emit_point & last_reg;
        push.push0_res = emit_point ? point_res : end_res;
        push.push1_res = end_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_contour_reg <= 1'b0;
            thresh_sq_reg  <= THRESH_SQ_RESET;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            kept_x_reg     <= '0;
            kept_y_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thresh_sq_reg <= thresh_sq_next;
            end
            if (point.ready)
            begin
                in_valid_reg <= point.valid;
            end
            if (consume)
            begin
                if (!in_contour_reg)
                begin
                    first_x_reg <= px_reg;
                    first_y_reg <= py_reg;
                    kept_x_reg  <= px_reg;
                    kept_y_reg  <= py_reg;
                end
                else if (emit_point)
                begin
                    kept_x_reg <= px_reg;
                    kept_y_reg <= py_reg;
                end
                in_contour_reg <= ~last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            px_reg   <= point.point_x;
            py_reg   <= point.point_y;
            last_reg <= point.last_point;
        end
    end

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1_en |-> push.push0_en)
        else $error("second result pushed without the first");

    a_open_after_point: assert property (@(posedge clk) disable iff (!rst_n)
        consume && !last_reg |=> in_contour_reg)
        else $error("contour not open after a non-closing point");

    a_closed_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        consume && last_reg |=> !in_contour_reg)
        else $error("contour still open after the closing point");

    a_end_marks_close: assert property (@(posedge clk) disable iff (!rst_n)
        push.push0_en && push.push0_res.end_of_contour |-> last_reg && !emit_point)
        else $error("end of contour pushed for a non-closing point");

endmodule

// ===== sv/cndf_fifo.sv =====
module cndf_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cndf_pkg::push_t                push,
    output logic [cndf_pkg::CNT_WIDTH-1:0] fifo_free,
    cndf_result_if.source                  result
);
    import cndf_pkg::*;

    result_t              entry_reg [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg;
    logic [PTR_WIDTH-1:0] wr_ptr_next;
    logic [PTR_WIDTH-1:0] wr_ptr_inc;
    logic [PTR_WIDTH-1:0] rd_ptr_reg;
    logic [CNT_WIDTH-1:0] count_reg;
    logic [CNT_WIDTH-1:0] count_next;
    logic [CNT_WIDTH-1:0] push_cnt;
    logic                 pop;
    result_t              head;

    assign wr_ptr_inc = wr_ptr_reg + PTR_WIDTH'(1);
    assign push_cnt   = CNT_WIDTH'(push.push0_en) + CNT_WIDTH'(push.push1_en);
    assign pop        = result.valid & result.ready;
    assign count_next = count_reg + push_cnt - CNT_WIDTH'(pop);
    assign wr_ptr_next = wr_ptr_reg + push_cnt[PTR_WIDTH-1:0];
    assign fifo_free  = CNT_WIDTH'(FIFO_DEPTH) - count_reg;

    assign head                  = entry_reg[rd_ptr_reg];
    assign result.valid          = (count_reg != '0);
    assign result.out_x          = head.out_x;
    assign result.out_y          = head.out_y;
    assign result.has_point      = head.has_point;
    assign result.end_of_contour = head.end_of_contour;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0_en)
        begin
            entry_reg[wr_ptr_reg] <= push.push0_res;
        end
        if (push.push1_en)
        begin
            entry_reg[wr_ptr_inc] <= push.push1_res;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_WIDTH'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt <= fifo_free)
        else $error("result queue overflow");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push_cnt == '0 |=> count_reg == $past(count_reg) - CNT_WIDTH'(1))
        else $error("result queue count wrong after a pop");

endmodule

// ===== sv/contour_near_duplicate_filter_unit.sv =====
// Thins the points of a closed contour by distance to the last kept point.
// The point channel carries one contour point per transaction; last_point marks
// the final point of a contour. The result channel carries the kept points and,
// for each contour, a closing transaction with end_of_contour set: either the
// first point again, or a bare end marker with has_point clear.
// min_distance is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the block is idle, which the block does not enforce.
// Its square is held in a register and used from the next cycle. A point is
// taken into an input register, tested against the kept point and its results
// written into a four-entry result queue that feeds the result channel.
// One point is accepted every cycle while the queue has room. A closing point
// that yields both a kept point and the closing transaction pushes two entries.
// When the receiver stalls the queue fills and ready on the point channel falls
// once the queue has no room for the results of the waiting point.
// Reset empties the queue, sets min_distance to 3 and waits for the first
// point of a new contour.
module contour_near_duplicate_filter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cndf_pkg::MIN_DIST_WIDTH-1:0] cfg_wr_data,
    cndf_point_if.sink                          point,
    cndf_result_if.source                       result
);
    import cndf_pkg::*;

    push_t                push;
    logic [CNT_WIDTH-1:0] fifo_free;

    cndf_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .point       (point),
        .fifo_free   (fifo_free),
        .push        (push)
    );

    cndf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .fifo_free (fifo_free),
        .result    (result)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import cndf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASE_COUNT = 8;
    localparam int FROM_PREDICTOR = -1;

    typedef struct {
        int      min_dist;
        coord_t  x;
        coord_t  y;
        logic    last;
        int      n_typed;
        result_t r0;
        result_t r1;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [MIN_DIST_WIDTH-1:0] cfg_wr_data;
    logic                      recv_ready = 1'b0;

    cndf_point_if  point_bus ();
    cndf_result_if result_bus ();

    assign result_bus.ready = recv_ready;

    contour_near_duplicate_filter_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .point       (point_bus),
        .result      (result_bus)
    );

    logic [MIN_DIST_WIDTH-1:0] min_dist;
    coord_t                    first_x;
    coord_t                    first_y;
    coord_t                    kept_x;
    coord_t                    kept_y;
    logic                      contour_open;

    result_t   pending_results[$];
    stim_row_t directed_rows[$];
    result_t   oldest_result;
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    int        stall_draw;
    bit        steady = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic result_t make_result(coord_t x, coord_t y, logic has, logic fin);
        result_t r;
        r.out_x = x;
        r.out_y = y;
        r.has_point = has;
        r.end_of_contour = fin;
        return r;
    endfunction

    function automatic result_t typed_result(int x, int y, logic has, logic fin);
        return make_result(coord_t'(x), coord_t'(y), has, fin);
    endfunction

    // Returns -1 when the points are closer than the threshold, 0 when exactly at
    // it and 1 when farther.
    function automatic int dist_rank(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                     logic [MIN_DIST_WIDTH-1:0] md);
        int dx;
        int dy;
        int d2;
        int t2;
        dx = int'(ax) - int'(bx);
        dy = int'(ay) - int'(by);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        if (dx >= 256 || dy >= 256)
            return 1;
        d2 = dx * dx + dy * dy;
        t2 = int'(md) * int'(md);
        if (d2 < t2)
            return -1;
        return (d2 == t2) ? 0 : 1;
    endfunction

    function int thin_point(coord_t x, coord_t y, logic last,
                            output result_t r0, output result_t r1);
        int      n;
        result_t closing;
        n = 0;
        r0 = '0;
        r1 = '0;
        if (!contour_open)
        begin
            first_x = x;
            first_y = y;
            kept_x = x;
            kept_y = y;
            contour_open = 1'b1;
        end
        else if (dist_rank(x, y, kept_x, kept_y, min_dist) >= 0)
        begin
            r0 = make_result(x, y, 1'b1, 1'b0);
            n = 1;
            kept_x = x;
            kept_y = y;
        end
        if (last)
        begin
            if (dist_rank(first_x, first_y, kept_x, kept_y, min_dist) > 0)
                closing = make_result(first_x, first_y, 1'b1, 1'b1);
            else
                closing = make_result('0, '0, 1'b0, 1'b1);
            if (n == 0)
                r0 = closing;
            else
                r1 = closing;
            n++;
            contour_open = 1'b0;
        end
        return n;
    endfunction

    function automatic int draw_gap();
        return steady ? 0 : int'($urandom_range(0, 4));
    endfunction

    function automatic int rand_delta(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic add_row(int md, int x, int y, int last, int n_typed,
                           result_t r0 = '0, result_t r1 = '0);
        stim_row_t row;
        row.min_dist = md;
        row.x = coord_t'(x);
        row.y = coord_t'(y);
        row.last = (last != 0);
        row.n_typed = n_typed;
        row.r0 = r0;
        row.r1 = r1;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic send_point(coord_t x, coord_t y, logic last, int n_typed,
                              result_t t0, result_t t1);
        int      gap;
        int      n;
        result_t r0;
        result_t r1;
        gap = draw_gap();
        if (gap > 0)
        begin
            point_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_bus.valid <= 1'b1;
        point_bus.point_x <= x;
        point_bus.point_y <= y;
        point_bus.last_point <= last;
        do
            @(posedge clk);
        while (!point_bus.ready);
        n = thin_point(x, y, last, r0, r1);
        if (n_typed != FROM_PREDICTOR)
        begin
            n = n_typed;
            r0 = t0;
            r1 = t1;
        end
        if (n > 0)
            pending_results.insert(pending_results.size(), r0);
        if (n > 1)
            pending_results.insert(pending_results.size(), r1);
    endtask

    // Points that produce no result may still be in flight when the last expected
    // result arrives, hence the extra cycles before the register write.
    task automatic write_min_distance(logic [MIN_DIST_WIDTH-1:0] value);
        point_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        min_dist = value;
    endtask

    task automatic random_phase(logic [MIN_DIST_WIDTH-1:0] md, int items);
        int     sent;
        int     len;
        int     span;
        int     pick;
        int     k;
        coord_t x;
        coord_t y;
        coord_t fx;
        coord_t fy;
        write_min_distance(md);
        steady = ($urandom_range(0, 3) == 0);
        span = int'(md) + 3;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_point(coord_t'($urandom), coord_t'($urandom), 1'($urandom_range(0, 1)),
                           FROM_PREDICTOR, '0, '0);
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 7) == 0) ? 1 : int'($urandom_range(2, 12));
                if ($urandom_range(0, 3) == 0)
                begin
                    x = coord_t'($urandom);
                    y = coord_t'($urandom);
                end
                else
                begin
                    x = coord_t'(int'($urandom_range(0, 2000)) - 1000);
                    y = coord_t'(int'($urandom_range(0, 2000)) - 1000);
                end
                fx = x;
                fy = y;
                for (k = 0; k < len; k++)
                begin
                    if (k > 0)
                    begin
                        pick = $urandom_range(0, 15);
                        if (k == len - 1 && pick < 2)
                        begin
                            x = coord_t'(int'(fx) + int'(md));
                            y = fy;
                        end
                        else if (k == len - 1 && pick < 6)
                        begin
                            x = coord_t'(int'(fx) + rand_delta(span));
                            y = coord_t'(int'(fy) + rand_delta(span));
                        end
                        else if (pick < 9)
                        begin
                            x = kept_x;
                            y = kept_y;
                            case ($urandom_range(0, 3))
                                0: x = coord_t'(int'(kept_x) + int'(md));
                                1: x = coord_t'(int'(kept_x) - int'(md));
                                2: y = coord_t'(int'(kept_y) + int'(md));
                                default: y = coord_t'(int'(kept_y) - int'(md));
                            endcase
                        end
                        else if (pick == 15)
                        begin
                            x = coord_t'($urandom);
                            y = coord_t'($urandom);
                        end
                        else
                        begin
                            x = coord_t'(int'(x) + rand_delta(span));
                            y = coord_t'(int'(y) + rand_delta(span));
                        end
                    end
                    send_point(x, y, (k == len - 1), FROM_PREDICTOR, '0, '0);
                end
                sent += len;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            recv_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (result_bus.valid && recv_ready)
        begin
            stall_draw = draw_gap();
            stall_left <= stall_draw;
            recv_ready <= (stall_draw == 0);
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else
        begin
            stall_left <= 0;
            recv_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                oldest_result = pending_results.pop_front();
                if (result_bus.out_x !== oldest_result.out_x)
                    report_mismatch($sformatf("out_x %0d, expected %0d",
                                              result_bus.out_x, oldest_result.out_x));
                if (result_bus.out_y !== oldest_result.out_y)
                    report_mismatch($sformatf("out_y %0d, expected %0d",
                                              result_bus.out_y, oldest_result.out_y));
                if (result_bus.has_point !== oldest_result.has_point)
                    report_mismatch($sformatf("has_point %b, expected %b",
                                              result_bus.has_point, oldest_result.has_point));
                if (result_bus.end_of_contour !== oldest_result.end_of_contour)
                    report_mismatch($sformatf("end_of_contour %b, expected %b",
                                              result_bus.end_of_contour,
                                              oldest_result.end_of_contour));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((point_bus.valid && point_bus.ready) || (result_bus.valid && result_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("contour_near_duplicate_filter_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        point_bus.valid = 1'b0;
        point_bus.point_x = '0;
        point_bus.point_y = '0;
        point_bus.last_point = 1'b0;
        min_dist = MIN_DIST_RESET;
        first_x = '0;
        first_y = '0;
        kept_x = '0;
        kept_y = '0;
        contour_open = 1'b0;

        add_row(3, 0, 0, 0, 0);
        add_row(3, 3, 0, 0, 1, typed_result(3, 0, 1'b1, 1'b0));
        add_row(3, 4, 2, 0, FROM_PREDICTOR);
        add_row(3, 32767, 32767, 0, 1, typed_result(32767, 32767, 1'b1, 1'b0));
        add_row(3, -32768, -32768, 0, 1, typed_result(-32768, -32768, 1'b1, 1'b0));
        add_row(3, -32768, -32766, 1, 1, typed_result(0, 0, 1'b1, 1'b1));
        add_row(3, 5, 5, 1, 1, typed_result(0, 0, 1'b0, 1'b1));
        add_row(3, 100, 100, 0, FROM_PREDICTOR);
        add_row(3, 103, 100, 0, FROM_PREDICTOR);
        add_row(3, 100, 100, 1, FROM_PREDICTOR);
        add_row(3, 0, 0, 0, FROM_PREDICTOR);
        add_row(3, 0, 3, 0, FROM_PREDICTOR);
        add_row(3, 2, 2, 1, FROM_PREDICTOR);
        add_row(255, 0, 0, 0, FROM_PREDICTOR);
        add_row(255, 180, 180, 0, FROM_PREDICTOR);
        add_row(255, 255, 0, 0, FROM_PREDICTOR);
        add_row(255, 0, -1, 1, FROM_PREDICTOR);
        add_row(0, 7, 7, 0, FROM_PREDICTOR);
        add_row(0, 7, 7, 0, FROM_PREDICTOR);
        add_row(0, 7, 7, 1, FROM_PREDICTOR);
        add_row(0, -1, -1, 1, 1, typed_result(0, 0, 1'b0, 1'b1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].min_dist != int'(min_dist))
                write_min_distance(MIN_DIST_WIDTH'(directed_rows[i].min_dist));
            send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                       directed_rows[i].n_typed, directed_rows[i].r0, directed_rows[i].r1);
        end

        random_phase(8'd0, RANDOM_ITEMS / PHASE_COUNT);
        random_phase(8'd255, RANDOM_ITEMS / PHASE_COUNT);
        random_phase(8'd1, RANDOM_ITEMS / PHASE_COUNT);
        random_phase(8'd3, RANDOM_ITEMS / PHASE_COUNT);
        random_phase(8'($urandom_range(0, 255)), RANDOM_ITEMS / PHASE_COUNT);
        random_phase(8'd254, RANDOM_ITEMS / PHASE_COUNT);
        random_phase(8'($urandom_range(2, 20)), RANDOM_ITEMS / PHASE_COUNT);
        random_phase(8'd5, RANDOM_ITEMS / PHASE_COUNT);

        point_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("contour_near_duplicate_filter_unit: match");
        else
            $display("contour_near_duplicate_filter_unit: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/cndf_pkg.sv
sv/cndf_point_if.sv
sv/cndf_result_if.sv
sv/cndf_dist.sv
sv/cndf_core.sv
sv/cndf_fifo.sv
sv/contour_near_duplicate_filter_unit.sv
dv/tb.sv
